>>> rtl/core/tx_descriptor_ring_macros.svh
// Assertion macros for the transmit descriptor ring
`ifndef TX_DESCRIPTOR_RING_MACROS_SVH
`define TX_DESCRIPTOR_RING_MACROS_SVH

// Same-cycle implication, disabled in reset
`define TXDR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tx_descriptor_ring: assertion failed");

// Next-cycle implication, disabled in reset
`define TXDR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tx_descriptor_ring: assertion failed");

`endif

>>> rtl/core/txdr_pkg.sv
// Shared types and constants for the transmit descriptor ring
`timescale 1ns / 1ps

package txdr_pkg;

    localparam int RING_DEPTH_DEFAULT = 8;

    localparam logic [15:0] MAX_LEN_RESET = 16'd1500;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_MAX_LEN = 1'b0;

    localparam int ACTION_W = 2;
    localparam int LEN_W    = 16;
    localparam int ADDR_W   = 32;
    localparam int DONE_W   = 3;
    localparam int CODE_W   = 2;
    localparam int SLOT_W   = 3;
    localparam int COUNT_W  = 4;

    localparam int IN_LEN_LSB  = 0;
    localparam int IN_ADDR_LSB = IN_LEN_LSB + LEN_W;
    localparam int IN_DONE_LSB = IN_ADDR_LSB + ADDR_W;
    localparam int IN_TDATA_W  = 56;

    localparam int OUT_CODE_LSB  = 0;
    localparam int OUT_SLOT_LSB  = OUT_CODE_LSB + CODE_W;
    localparam int OUT_PLEN_LSB  = OUT_SLOT_LSB + SLOT_W;
    localparam int OUT_PADDR_LSB = OUT_PLEN_LSB + LEN_W;
    localparam int OUT_WRAP_LSB  = OUT_PADDR_LSB + ADDR_W;
    localparam int OUT_RCL_LSB   = OUT_WRAP_LSB + 1;
    localparam int OUT_FREE_LSB  = OUT_RCL_LSB + COUNT_W;
    localparam int OUT_USED_W    = OUT_FREE_LSB + COUNT_W;
    localparam int OUT_TDATA_W   = 64;

    localparam logic [ACTION_W-1:0] ACT_SEND  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_DONE  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_RESET = 2'd2;

    localparam logic [CODE_W-1:0] RES_OK      = 2'd0;
    localparam logic [CODE_W-1:0] RES_BAD_LEN = 2'd1;
    localparam logic [CODE_W-1:0] RES_FULL    = 2'd2;

    typedef struct packed {
        logic load;
        logic walk_step;
        logic commit;
    } txdr_cmd_t;

    typedef struct packed {
        logic in_send;
        logic walk_done;
        logic out_free;
    } txdr_sts_t;

endpackage

>>> rtl/core/tx_descriptor_ring.sv
// Transmit descriptor ring manager, top level
// Requests enter on the s_axis channel: tuser carries the action (send, done,
// ring reset), tdata the frame length, buffer address and done slot. Each
// request gives exactly one result on the m_axis channel, held in an output
// register until the transaction completes. The APB port holds the maximum
// frame length (offset 0x0, reset 1500); the user must write it only while
// idle, as the block itself does not enforce this. A send walks the reclaim
// pointer one slot per cycle until it meets a slot still marked ready or the
// ring is all free, then decides and either posts the frame or rejects it.
// The result is registered in the commit cycle and appears in the cycle after.
// The reclaim walk sets the send rate: one ring slot per cycle.
// A new request is taken while an earlier result still waits; a stalled
// receiver holds the block in its commit state until the register frees.
// Reset empties the ring: marks cleared, pointers zero, all slots free.
`timescale 1ns / 1ps
`include "tx_descriptor_ring_macros.svh"

module tx_descriptor_ring
    import txdr_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // s_axis_tdata: length[15:0], buffer_address[47:16],
    // done_index[50:48], zero pad[55:51]
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // s_axis_tuser: action[1:0]
    input  logic [ACTION_W-1:0]    s_axis_tuser,
    // m_axis_tdata: result_code[1:0], slot_index[4:2], posted_length[20:5],
    // posted_address[52:21], wrap_mark[53], reclaimed_count[57:54],
    // free_count[61:58], zero pad[63:62]
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    logic [LEN_W-1:0] max_len;
    txdr_cmd_t        cmd;
    txdr_sts_t        sts;

    txdr_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .max_len (max_len)
    );

    txdr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    txdr_datapath #(
        .RING_DEPTH (RING_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (s_axis_tdata),
        .in_action (s_axis_tuser),
        .max_len   (max_len),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

    `TXDR_ASSERT_NEXT(a_busy_after_accept, clk, rst_n,
        s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `TXDR_ASSERT_IMPL(a_posted_is_ok, clk, rst_n,
        m_axis_tvalid && (m_axis_tdata[OUT_PLEN_LSB +: LEN_W] != '0),
        m_axis_tdata[OUT_CODE_LSB +: CODE_W] == RES_OK)
    `TXDR_ASSERT_IMPL(a_wrap_only_when_posted, clk, rst_n,
        m_axis_tvalid && m_axis_tdata[OUT_WRAP_LSB],
        m_axis_tdata[OUT_PLEN_LSB +: LEN_W] != '0)

endmodule

>>> rtl/core/txdr_regs.sv
// Configuration register block holding the maximum frame length
`timescale 1ns / 1ps

module txdr_regs
    import txdr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [LEN_W-1:0]      max_len
);

    logic [LEN_W-1:0] max_len_reg;
    logic [LEN_W-1:0] max_len_next;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_MAX_LEN);

    always_comb
    begin
        max_len_next = max_len_reg;
        if (wr_en)
        begin
            max_len_next = pwdata[LEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_LEN_RESET;
        end
        else
        begin
            max_len_reg <= max_len_next;
        end
    end

    assign prdata  = (paddr[2] == REG_MAX_LEN) ?
                     {{(APB_DATA_W-LEN_W){1'b0}}, max_len_reg} : '0;
    assign max_len = max_len_reg;

endmodule

>>> rtl/core/txdr_ctrl.sv
// Controller state machine sequencing accept, reclaim walk and commit
`timescale 1ns / 1ps

module txdr_ctrl
    import txdr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  txdr_sts_t  sts,
    output txdr_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_WALK   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next    = state_reg;
        in_ready      = 1'b0;
        cmd.load      = 1'b0;
        cmd.walk_step = 1'b0;
        cmd.commit    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = sts.in_send ? ST_WALK : ST_FINISH;
                end
            end
            ST_WALK:
            begin
                if (sts.walk_done)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.walk_step = 1'b1;
                end
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/core/txdr_datapath.sv
// Datapath: ring marks, pointers, free count and the result register
`timescale 1ns / 1ps

module txdr_datapath
    import txdr_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [IN_TDATA_W-1:0]  in_data,
    input  logic [ACTION_W-1:0]    in_action,
    input  logic [LEN_W-1:0]       max_len,
    input  txdr_cmd_t              cmd,
    output txdr_sts_t              sts,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [OUT_TDATA_W-1:0] out_data
);

    localparam int PW = $clog2(RING_DEPTH);
    localparam int CW = $clog2(RING_DEPTH + 1);
    localparam logic [PW-1:0] LAST_SLOT = PW'(RING_DEPTH - 1);
    localparam logic [CW-1:0] FULL_FREE = CW'(RING_DEPTH);

    function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
        return (p == LAST_SLOT) ? '0 : p + 1'b1;
    endfunction

    logic [ACTION_W-1:0]    action_reg, action_next;
    logic [LEN_W-1:0]       len_reg, len_next;
    logic [ADDR_W-1:0]      addr_reg, addr_next;
    logic [DONE_W-1:0]      done_reg, done_next;
    logic [RING_DEPTH-1:0]  ready_reg, ready_next;
    logic [PW-1:0]          fill_reg, fill_next;
    logic [PW-1:0]          rclm_reg, rclm_next;
    logic [CW-1:0]          free_reg, free_next;
    logic [CW-1:0]          rc_reg, rc_next;
    logic                   out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;

    logic [CODE_W-1:0]      res_code;
    logic [PW-1:0]          res_slot;
    logic                   posted;
    logic                   len_bad;

    assign len_bad = (len_reg == '0) || (len_reg > max_len);

    assign sts.in_send   = (in_action == ACT_SEND);
    assign sts.walk_done = (free_reg == FULL_FREE) || ready_reg[rclm_reg];
    assign sts.out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        action_next    = action_reg;
        len_next       = len_reg;
        addr_next      = addr_reg;
        done_next      = done_reg;
        ready_next     = ready_reg;
        fill_next      = fill_reg;
        rclm_next      = rclm_reg;
        free_next      = free_reg;
        rc_next        = rc_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;
        res_code       = RES_OK;
        res_slot       = fill_reg;
        posted         = 1'b0;

        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.load)
        begin
            action_next = in_action;
            len_next    = in_data[IN_LEN_LSB +: LEN_W];
            addr_next   = in_data[IN_ADDR_LSB +: ADDR_W];
            done_next   = in_data[IN_DONE_LSB +: DONE_W];
            rc_next     = '0;
        end

        if (cmd.walk_step)
        begin
            free_next = free_reg + 1'b1;
            rc_next   = rc_reg + 1'b1;
            rclm_next = next_ptr(rclm_reg);
        end

        if (cmd.commit)
        begin
            unique case (action_reg)
                ACT_SEND:
                begin
                    if (len_bad)
                    begin
                        res_code = RES_BAD_LEN;
                    end
                    else if (free_reg == '0)
                    begin
                        res_code = RES_FULL;
                    end
                    else
                    begin
                        posted               = 1'b1;
                        ready_next[fill_reg] = 1'b1;
                        fill_next            = next_ptr(fill_reg);
                        free_next            = free_reg - 1'b1;
                    end
                end
                ACT_DONE:
                begin
                    for (int i = 0; i < RING_DEPTH; i++)
                    begin
                        if (int'(done_reg) == i)
                        begin
                            ready_next[i] = 1'b0;
                        end
                    end
                end
                ACT_RESET:
                begin
                    ready_next = '0;
                    fill_next  = '0;
                    rclm_next  = '0;
                    free_next  = FULL_FREE;
                end
                default:
                begin
                    res_code = RES_OK;
                end
            endcase

            res_slot = posted ? fill_reg : fill_next;

            out_data_next = '0;
            out_data_next[OUT_CODE_LSB +: CODE_W]  = res_code;
            out_data_next[OUT_SLOT_LSB +: SLOT_W]  = SLOT_W'(res_slot);
            out_data_next[OUT_PLEN_LSB +: LEN_W]   = posted ? len_reg : '0;
            out_data_next[OUT_PADDR_LSB +: ADDR_W] = posted ? addr_reg : '0;
            out_data_next[OUT_WRAP_LSB]            = posted && (fill_reg == LAST_SLOT);
            out_data_next[OUT_RCL_LSB +: COUNT_W]  = COUNT_W'(rc_reg);
            out_data_next[OUT_FREE_LSB +: COUNT_W] = COUNT_W'(free_next);
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_reg     <= '0;
            fill_reg      <= '0;
            rclm_reg      <= '0;
            free_reg      <= FULL_FREE;
            rc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ready_reg     <= ready_next;
            fill_reg      <= fill_next;
            rclm_reg      <= rclm_next;
            free_reg      <= free_next;
            rc_reg        <= rc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg   <= action_next;
        len_reg      <= len_next;
        addr_reg     <= addr_next;
        done_reg     <= done_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> sim/tx_descriptor_ring_tb.sv
// Self-checking testbench for the transmit descriptor ring manager
`timescale 1ns / 1ps

module tx_descriptor_ring_tb;
    import txdr_pkg::*;

    localparam int RING = RING_DEPTH_DEFAULT;
    localparam int CYCLE_LIMIT = 800_000;
    localparam int HOLD_CYCLES = 300;
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam logic [APB_ADDR_W-1:0] MAX_LEN_ADDR = APB_ADDR_W'(4 * REG_MAX_LEN);

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [LEN_W-1:0]    tx_len;
        logic [ADDR_W-1:0]   buffer_address;
        logic [DONE_W-1:0]   done_index;
    } ring_request_t;

    typedef struct packed {
        logic [CODE_W-1:0]  result_code;
        logic [SLOT_W-1:0]  slot_index;
        logic [LEN_W-1:0]   posted_length;
        logic [ADDR_W-1:0]  posted_address;
        logic               wrap_mark;
        logic [COUNT_W-1:0] reclaimed_count;
        logic [COUNT_W-1:0] free_count;
    } ring_reply_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [ACTION_W-1:0]    s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr = '0;
    logic [APB_DATA_W-1:0]  pwdata = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    ring_request_t queued_requests[$];
    ring_reply_t   awaited_replies[$];

    logic              slot_busy [RING];
    int                fill_ptr;
    int                reclaim_ptr;
    int                free_slots;
    logic [LEN_W-1:0]  max_len = MAX_LEN_RESET;

    int unsigned failures = 0;
    int unsigned requests_accepted = 0;
    int unsigned replies_seen = 0;
    int unsigned frames_posted = 0;
    int unsigned length_rejects = 0;
    int unsigned full_rejects = 0;
    int unsigned slots_reclaimed = 0;
    int unsigned cycles = 0;
    int unsigned send_gap = 0;
    int unsigned send_quiet = 0;
    int unsigned rcv_stall = 0;
    int unsigned rcv_quiet = 0;
    int unsigned hold_left = 0;
    int unsigned holds_done = 0;

    tx_descriptor_ring #(
        .RING_DEPTH(RING)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always #6 clk = ~clk;

    function automatic void clear_ring();
        for (int i = 0; i < RING; i++)
            slot_busy[i] = 1'b0;
        fill_ptr = 0;
        reclaim_ptr = 0;
        free_slots = RING;
    endfunction

    function automatic ring_reply_t apply_request(input ring_request_t req);
        ring_reply_t r;
        bit posted;
        r = '0;
        r.result_code = RES_OK;
        posted = 1'b0;
        case (req.action)
            ACT_SEND:
            begin
                while (free_slots < RING && !slot_busy[reclaim_ptr])
                begin
                    free_slots++;
                    r.reclaimed_count = r.reclaimed_count + 1'b1;
                    reclaim_ptr = (reclaim_ptr + 1) % RING;
                end
                if (req.tx_len == '0 || req.tx_len > max_len)
                    r.result_code = RES_BAD_LEN;
                else if (free_slots == 0)
                    r.result_code = RES_FULL;
                else
                begin
                    posted = 1'b1;
                    r.slot_index = SLOT_W'(fill_ptr);
                    r.posted_length = req.tx_len;
                    r.posted_address = req.buffer_address;
                    r.wrap_mark = (fill_ptr == RING - 1);
                    slot_busy[fill_ptr] = 1'b1;
                    fill_ptr = (fill_ptr + 1) % RING;
                    free_slots--;
                end
            end
            ACT_DONE:
            begin
                if (int'(req.done_index) < RING)
                    slot_busy[req.done_index] = 1'b0;
            end
            ACT_RESET:
                clear_ring();
            default:
                ;
        endcase
        if (!posted)
            r.slot_index = SLOT_W'(fill_ptr);
        r.free_count = COUNT_W'(free_slots);
        return r;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else if (roll < 98)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] expected,
                                          input logic [31:0] actual);
        if (expected !== actual)
        begin
            $error("%s: expected %0h, got %0h", name, expected, actual);
            failures++;
        end
    endfunction

    function automatic void enqueue(input logic [ACTION_W-1:0] action,
                                    input logic [LEN_W-1:0] tx_len,
                                    input logic [ADDR_W-1:0] buffer_address,
                                    input logic [DONE_W-1:0] done_index);
        ring_request_t req;
        req.action = action;
        req.tx_len = tx_len;
        req.buffer_address = buffer_address;
        req.done_index = done_index;
        queued_requests.push_back(req);
    endfunction

    function automatic void enqueue_random();
        int unsigned roll;
        logic [ACTION_W-1:0] action;
        logic [LEN_W-1:0] len;
        logic [ADDR_W-1:0] addr;
        roll = $urandom_range(0, 99);
        if (roll < 56)
            action = ACT_SEND;
        else if (roll < 92)
            action = ACT_DONE;
        else if (roll < 96)
            action = ACT_RESET;
        else
            action = ACT_UNUSED;
        roll = $urandom_range(0, 99);
        if (roll < 75 && max_len != '0)
            len = LEN_W'($urandom_range(1, max_len));
        else if (roll < 83)
            len = '0;
        else if (roll < 90)
            len = max_len;
        else if (roll < 95 && max_len != '1)
            len = max_len + 1'b1;
        else
            len = LEN_W'($urandom_range(0, 65535));
        roll = $urandom_range(0, 19);
        if (roll == 0)
            addr = '0;
        else if (roll == 1)
            addr = '1;
        else
            addr = $urandom;
        enqueue(action, len, addr, DONE_W'($urandom_range(0, 7)));
    endfunction

    task automatic wait_idle();
        do
            @(negedge clk);
        while (queued_requests.size() != 0 || s_axis_tvalid || awaited_replies.size() != 0);
    endtask

    task automatic set_max_length(input logic [LEN_W-1:0] value);
        wait_idle();
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= MAX_LEN_ADDR;
        pwdata <= APB_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        max_len = value;
        @(negedge clk);
    endtask

    // request driver
    always @(posedge clk)
    begin
        logic [IN_TDATA_W-1:0] word;
        ring_request_t req;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                req = queued_requests.pop_front();
                awaited_replies.push_back(apply_request(req));
                requests_accepted++;
                if (send_quiet != 0)
                begin
                    send_quiet--;
                    send_gap = 0;
                end
                else
                begin
                    send_gap = pick_gap();
                    if ($urandom_range(0, 49) == 0)
                        send_quiet = $urandom_range(20, 80);
                end
            end
            if (send_gap != 0)
            begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end
            else if (queued_requests.size() != 0)
            begin
                req = queued_requests[0];
                word = '0;
                word[IN_LEN_LSB +: LEN_W] = req.tx_len;
                word[IN_ADDR_LSB +: ADDR_W] = req.buffer_address;
                word[IN_DONE_LSB +: DONE_W] = req.done_index;
                s_axis_tdata <= word;
                s_axis_tuser <= req.action;
                s_axis_tvalid <= 1'b1;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // long receiver hold-off to back the ring up
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left != 0)
                hold_left <= hold_left - 1;
            else if (holds_done < 2 && requests_accepted >= 300 + 450 * holds_done)
            begin
                hold_left <= HOLD_CYCLES;
                holds_done <= holds_done + 1;
            end
        end
    end

    // reply monitor
    always @(posedge clk)
    begin
        logic ready_next;
        ring_reply_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            replies_seen++;
            if (awaited_replies.size() == 0)
            begin
                $error("reply with no request outstanding: %0h", m_axis_tdata);
                failures++;
            end
            else
            begin
                want = awaited_replies.pop_front();
                compare_field("result_code", 32'(want.result_code),
                              32'(m_axis_tdata[OUT_CODE_LSB +: CODE_W]));
                compare_field("slot_index", 32'(want.slot_index),
                              32'(m_axis_tdata[OUT_SLOT_LSB +: SLOT_W]));
                compare_field("posted_length", 32'(want.posted_length),
                              32'(m_axis_tdata[OUT_PLEN_LSB +: LEN_W]));
                compare_field("posted_address", want.posted_address,
                              m_axis_tdata[OUT_PADDR_LSB +: ADDR_W]);
                compare_field("wrap_mark", 32'(want.wrap_mark),
                              32'(m_axis_tdata[OUT_WRAP_LSB]));
                compare_field("reclaimed_count", 32'(want.reclaimed_count),
                              32'(m_axis_tdata[OUT_RCL_LSB +: COUNT_W]));
                compare_field("free_count", 32'(want.free_count),
                              32'(m_axis_tdata[OUT_FREE_LSB +: COUNT_W]));
                if (want.result_code == RES_OK && want.posted_length != '0)
                    frames_posted++;
                else if (want.result_code == RES_BAD_LEN)
                    length_rejects++;
                else if (want.result_code == RES_FULL)
                    full_rejects++;
                slots_reclaimed += want.reclaimed_count;
            end
        end
        if (hold_left != 0)
            ready_next = 1'b0;
        else if (rcv_stall != 0)
        begin
            rcv_stall--;
            ready_next = 1'b0;
        end
        else if (rcv_quiet != 0)
        begin
            rcv_quiet--;
            ready_next = 1'b1;
        end
        else
        begin
            rcv_stall = pick_gap();
            ready_next = (rcv_stall == 0);
            if (rcv_stall != 0)
                rcv_stall--;
            if ($urandom_range(0, 39) == 0)
                rcv_quiet = $urandom_range(20, 80);
        end
        m_axis_tready <= ready_next;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d replies outstanding",
                     cycles, awaited_replies.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        clear_ring();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset limit of 1500: rejections, fill to full, reclaim, odd actions
        enqueue(ACT_SEND, '0, '1, '0);
        enqueue(ACT_SEND, MAX_LEN_RESET + 1'b1, $urandom, '1);
        enqueue(ACT_SEND, MAX_LEN_RESET, '1, 3'd7);
        enqueue(ACT_SEND, 16'd1, '0, '0);
        for (int i = 2; i < RING; i++)
            enqueue(ACT_SEND, LEN_W'(64 * i), $urandom, DONE_W'(i));
        enqueue(ACT_SEND, 16'd100, $urandom, '0);
        enqueue(ACT_DONE, '0, '0, 3'd0);
        enqueue(ACT_DONE, '0, '0, 3'd0);
        enqueue(ACT_DONE, '1, '1, 3'd1);
        enqueue(ACT_DONE, '0, '0, 3'd5);
        enqueue(ACT_SEND, 16'd60, $urandom, '0);
        enqueue(ACT_UNUSED, '1, '1, '1);
        enqueue(ACT_RESET, '1, '1, '1);
        enqueue(ACT_SEND, '1, $urandom, '0);

        set_max_length('1);
        enqueue(ACT_SEND, '1, '1, '1);
        enqueue(ACT_SEND, '0, $urandom, '0);
        enqueue(ACT_RESET, '0, '0, '0);

        set_max_length('0);
        enqueue(ACT_SEND, 16'd1, $urandom, '0);
        enqueue(ACT_SEND, '1, $urandom, '0);

        set_max_length(16'd1);
        enqueue(ACT_SEND, 16'd1, $urandom, '0);
        enqueue(ACT_SEND, 16'd2, $urandom, '0);

        set_max_length(MAX_LEN_RESET);
        repeat (205) enqueue_random();
        set_max_length('1);
        repeat (205) enqueue_random();
        set_max_length(16'd64);
        repeat (205) enqueue_random();
        set_max_length(LEN_W'($urandom_range(1, 65535)));
        repeat (205) enqueue_random();
        set_max_length(16'd1);
        repeat (205) enqueue_random();

        wait_idle();
        repeat (20) @(posedge clk);

        $display("%0d requests checked: %0d frames posted, %0d bad lengths, %0d ring full",
                 replies_seen, frames_posted, length_rejects, full_rejects);
        $display("%0d descriptors reclaimed; limits 0, 1, 64, 1500, 65535 and one random",
                 slots_reclaimed);
        if (failures == 0 && awaited_replies.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> tx_descriptor_ring.f
+incdir+rtl/core
rtl/core/txdr_pkg.sv
rtl/core/txdr_regs.sv
rtl/core/txdr_ctrl.sv
rtl/core/txdr_datapath.sv
rtl/core/tx_descriptor_ring.sv
sim/tx_descriptor_ring_tb.sv
